>>> hdl/ppc_pkg.sv
package ppc_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int NORM_FRAC_BITS  = 16;
    localparam int NCOMP           = 5;
    localparam int COORD_W         = 32;
    localparam int NORM_W          = 18;
    localparam int DIST_W          = 37;
    localparam int DEN_W           = DIST_W + 1;
    localparam int ACC_W           = NORM_W + COORD_W + 2;
    localparam int DPROD_W         = NORM_W + COORD_W;
    localparam int LPROD_W         = COORD_W + COORD_FRAC_BITS + 2;
    localparam int DIV_CNT_W       = $clog2(COORD_FRAC_BITS + 1);
    localparam int PADDR_W         = 4;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIST_W-1:0]  dist_t;
    typedef logic signed [NORM_W-1:0]  norm_t;
    typedef coord_t vert_t [NCOMP];

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DOT,
        ST_DIST,
        ST_NEXT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_LERP,
        ST_EMIT
    } state_t;

    // which result of the current item is being built
    typedef enum logic [1:0] {
        PH_ENTER,
        PH_KEEP,
        PH_CLOSE,
        PH_MARK
    } phase_t;

    typedef enum logic [1:0] {
        REG_NORMAL_X,
        REG_NORMAL_Y,
        REG_NORMAL_Z,
        REG_DISTANCE
    } reg_idx_t;

    typedef struct packed {
        logic                    start;
        logic [DIST_W-1:0]       num;
        logic [DEN_W-1:0]        den;
    } div_req_t;

    typedef struct packed {
        logic                       done;
        logic [COORD_FRAC_BITS-1:0] quo;
    } div_rsp_t;

    // strict crossing: both nonzero and of opposite sign
    function automatic logic crosses(dist_t a, dist_t b);
        crosses = (a != '0) && (b != '0) && (a[DIST_W-1] != b[DIST_W-1]);
    endfunction

endpackage

>>> hdl/ppc_if.sv
interface ppc_in_if;
    import ppc_pkg::*;
    logic   valid;
    logic   ready;
    coord_t in_x;
    coord_t in_y;
    coord_t in_z;
    coord_t in_s;
    coord_t in_t;
    logic   in_last;

    modport source (output valid, in_x, in_y, in_z, in_s, in_t, in_last, input ready);
    modport sink   (input valid, in_x, in_y, in_z, in_s, in_t, in_last, output ready);
endinterface

interface ppc_out_if;
    import ppc_pkg::*;
    logic   valid;
    logic   ready;
    coord_t out_x;
    coord_t out_y;
    coord_t out_z;
    coord_t out_s;
    coord_t out_t;
    logic   out_valid;
    logic   out_last;

    modport source (output valid, out_x, out_y, out_z, out_s, out_t, out_valid, out_last,
                    input ready);
    modport sink   (input valid, out_x, out_y, out_z, out_s, out_t, out_valid, out_last,
                    output ready);
endinterface

>>> hdl/ppc_div.sv
module ppc_div (
    input  logic              clk,
    input  logic              rst_n,
    input  ppc_pkg::div_req_t req,
    output ppc_pkg::div_rsp_t rsp
);
    import ppc_pkg::*;

    // restoring division, one quotient bit per cycle; num < den so the
    // quotient is a pure fraction of COORD_FRAC_BITS bits
    logic [DEN_W:0]               rem_reg;
    logic [DEN_W-1:0]             den_reg;
    logic [COORD_FRAC_BITS-1:0]   quo_reg;
    logic [DIV_CNT_W-1:0]         cnt_reg;
    logic [DEN_W:0]               trial;

    assign trial = {rem_reg[DEN_W-1:0], 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (req.start)
        begin
            cnt_reg <= DIV_CNT_W'(COORD_FRAC_BITS);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= {2'b00, req.num};
            den_reg <= req.den;
            quo_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_reg <= trial - {1'b0, den_reg};
                quo_reg <= {quo_reg[COORD_FRAC_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[COORD_FRAC_BITS-2:0], 1'b0};
            end
        end
    end

    assign rsp.done = (cnt_reg == '0);
    assign rsp.quo  = quo_reg;

endmodule

>>> hdl/polygon_plane_clipper_unit.sv
// Channel  Dir  Handshake     Payload
// in_ch    in   valid/ready   in_x in_y in_z in_s in_t in_last
// out_ch   out  valid/ready   out_x out_y out_z out_s out_t out_valid out_last
// apb      in   psel/penable  paddr[3:0] pwdata/prdata 32b, pready tied high
//
// Each item may emit a kept vertex or an end marker, plus an edge split for
// each plane crossing (up to two per item). The shared serial divider, one
// quotient bit a cycle, sets the split cost; the dot product and the five
// lerps share one multiplier. Reset is asynchronous, active low; it resets
// control state and the plane registers. A stalled result holds in the
// output register; the sequencer waits there and takes no new item until
// the item's last result is loaded.
module polygon_plane_clipper_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ppc_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    ppc_in_if.sink                        in_ch,
    ppc_out_if.source                     out_ch
);
    import ppc_pkg::*;

    // plane registers
    norm_t  nx_reg, ny_reg, nz_reg;
    coord_t pd_reg;

    // sequencer
    state_t state_reg, state_next;
    phase_t phase_reg;
    logic [1:0] k_reg;          // dot product step
    logic [2:0] j_reg;          // lerp step

    // item and polygon state
    vert_t  v_reg, prev_reg, first_reg, res_reg;
    dist_t  d_reg, prev_d_reg, first_d_reg;
    logic   last_reg, have_first_reg;
    logic   pend_a_reg, pend_b_reg, pend_c_reg, pend_m_reg;
    logic   res_vld_reg;

    // shared multiplier results and the divider quotient
    logic signed [DPROD_W-1:0] dprod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [LPROD_W-1:0] lprod_reg;
    logic [COORD_FRAC_BITS-1:0] frac_reg;

    // output register
    logic   ovalid_reg;

    // control
    logic   in_fire, emit_fire, div_start;
    div_req_t div_req;
    div_rsp_t div_rsp;

    // ---------------- configuration ----------------
    logic     cfg_wr;
    reg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nx_reg <= '0;
            ny_reg <= '0;
            nz_reg <= NORM_W'(65536);
            pd_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_NORMAL_X: nx_reg <= pwdata[NORM_W-1:0];
                REG_NORMAL_Y: ny_reg <= pwdata[NORM_W-1:0];
                REG_NORMAL_Z: nz_reg <= pwdata[NORM_W-1:0];
                REG_DISTANCE: pd_reg <= pwdata;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_NORMAL_X: prdata = {{(32-NORM_W){nx_reg[NORM_W-1]}}, nx_reg};
            REG_NORMAL_Y: prdata = {{(32-NORM_W){ny_reg[NORM_W-1]}}, ny_reg};
            REG_NORMAL_Z: prdata = {{(32-NORM_W){nz_reg[NORM_W-1]}}, nz_reg};
            REG_DISTANCE: prdata = pd_reg;
        endcase
    end

    // ---------------- operand selection ----------------
    // entering edge runs prev -> v, closing edge runs v -> first
    vert_t a_sel, b_sel;
    dist_t da_sel, db_sel;

    always_comb
    begin
        if (phase_reg == PH_CLOSE)
        begin
            a_sel  = v_reg;
            b_sel  = first_reg;
            da_sel = d_reg;
            db_sel = first_d_reg;
        end
        else
        begin
            a_sel  = prev_reg;
            b_sel  = v_reg;
            da_sel = prev_d_reg;
            db_sel = d_reg;
        end
    end

    logic signed [DEN_W-1:0] ddiff;
    assign ddiff = {da_sel[DIST_W-1], da_sel} - {db_sel[DIST_W-1], db_sel};

    assign div_req.start = div_start;
    assign div_req.num   = da_sel[DIST_W-1] ? DIST_W'(-da_sel) : da_sel;
    assign div_req.den   = ddiff[DEN_W-1] ? DEN_W'(-ddiff) : ddiff;

    ppc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ---------------- shared multiplier ----------------
    // normal x coordinate during the dot product, frac x (b - a) during lerps
    logic signed [NORM_W-1:0]        mul_a;
    logic signed [COORD_W:0]         mul_b;
    logic signed [NORM_W+COORD_W:0]  mul_p;

    always_comb
    begin
        if (state_reg == ST_LERP && j_reg < 3'(NCOMP))
        begin
            mul_a = {{(NORM_W-COORD_FRAC_BITS){1'b0}}, frac_reg};
            mul_b = {b_sel[j_reg][COORD_W-1], b_sel[j_reg]} -
                    {a_sel[j_reg][COORD_W-1], a_sel[j_reg]};
        end
        else
        begin
            unique case (k_reg)
                2'd0:
                begin
                    mul_a = nx_reg;
                    mul_b = {v_reg[0][COORD_W-1], v_reg[0]};
                end
                2'd1:
                begin
                    mul_a = ny_reg;
                    mul_b = {v_reg[1][COORD_W-1], v_reg[1]};
                end
                default:
                begin
                    mul_a = nz_reg;
                    mul_b = {v_reg[2][COORD_W-1], v_reg[2]};
                end
            endcase
        end
    end

    assign mul_p = mul_a * mul_b;

    // ---------------- distance ----------------
    logic signed [ACC_W-1:0] acc_shift;
    dist_t d_calc, first_d_eff;
    logic  ca, cb, cc;

    assign acc_shift   = acc_reg >>> NORM_FRAC_BITS;
    assign d_calc      = acc_shift[DIST_W-1:0] - {{(DIST_W-COORD_W){pd_reg[COORD_W-1]}}, pd_reg};
    assign first_d_eff = have_first_reg ? first_d_reg : d_calc;
    assign ca          = have_first_reg && crosses(prev_d_reg, d_calc);
    assign cb          = !d_calc[DIST_W-1];
    assign cc          = last_reg && crosses(d_calc, first_d_eff);

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (in_ch.valid) state_next = ST_DOT;
            ST_DOT:      if (k_reg == 2'd3) state_next = ST_DIST;
            ST_DIST:     state_next = ST_NEXT;
            ST_NEXT:
            begin
                priority if (pend_a_reg) state_next = ST_DIV_GO;
                else if (pend_b_reg)     state_next = ST_EMIT;
                else if (pend_c_reg)     state_next = ST_DIV_GO;
                else if (pend_m_reg)     state_next = ST_EMIT;
                else                     state_next = ST_IDLE;
            end
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: if (div_rsp.done) state_next = ST_LERP;
            ST_LERP:     if (j_reg == 3'(NCOMP)) state_next = ST_EMIT;
            ST_EMIT:     if (emit_fire) state_next = ST_NEXT;
            default:     state_next = ST_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb
    begin
        in_ch.ready = (state_reg == ST_IDLE);
        div_start   = (state_reg == ST_DIV_GO);
        emit_fire   = (state_reg == ST_EMIT) && (!ovalid_reg || out_ch.ready);
        in_fire     = in_ch.valid && in_ch.ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            have_first_reg <= 1'b0;
            ovalid_reg     <= 1'b0;
            pend_a_reg     <= 1'b0;
            pend_b_reg     <= 1'b0;
            pend_c_reg     <= 1'b0;
            pend_m_reg     <= 1'b0;
            k_reg          <= '0;
            j_reg          <= '0;
            phase_reg      <= PH_ENTER;
        end
        else
        begin
            state_reg <= state_next;

            if (emit_fire)
                ovalid_reg <= 1'b1;
            else if (out_ch.ready)
                ovalid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:  k_reg <= '0;
                ST_DOT:   k_reg <= k_reg + 1'b1;
                ST_DIST:
                begin
                    pend_a_reg <= ca;
                    pend_b_reg <= cb;
                    pend_c_reg <= cc;
                    pend_m_reg <= last_reg && !ca && !cb && !cc;
                    if (!have_first_reg)
                        have_first_reg <= 1'b1;
                end
                ST_NEXT:
                begin
                    j_reg <= '0;
                    priority if (pend_a_reg)
                    begin
                        pend_a_reg <= 1'b0;
                        phase_reg  <= PH_ENTER;
                    end
                    else if (pend_b_reg)
                    begin
                        pend_b_reg <= 1'b0;
                        phase_reg  <= PH_KEEP;
                    end
                    else if (pend_c_reg)
                    begin
                        pend_c_reg <= 1'b0;
                        phase_reg  <= PH_CLOSE;
                    end
                    else if (pend_m_reg)
                    begin
                        pend_m_reg <= 1'b0;
                        phase_reg  <= PH_MARK;
                    end
                    else if (last_reg)
                        have_first_reg <= 1'b0;
                end
                ST_LERP:  j_reg <= j_reg + 1'b1;
                default:  ;
            endcase
        end
    end

    // ---------------- datapath ----------------
    logic signed [LPROD_W-1:0] lprod_shift;
    logic [2:0] jm1;
    assign lprod_shift = lprod_reg >>> COORD_FRAC_BITS;
    assign jm1         = j_reg - 1'b1;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            v_reg[0] <= in_ch.in_x;
            v_reg[1] <= in_ch.in_y;
            v_reg[2] <= in_ch.in_z;
            v_reg[3] <= in_ch.in_s;
            v_reg[4] <= in_ch.in_t;
            last_reg <= in_ch.in_last;
            acc_reg  <= '0;
        end

        if (state_reg == ST_DOT)
        begin
            // one 18x32 product a cycle, accumulated the cycle after
            if (k_reg != 2'd3)
                dprod_reg <= mul_p[DPROD_W-1:0];
            if (k_reg != 2'd0)
                acc_reg <= acc_reg + {{(ACC_W-DPROD_W){dprod_reg[DPROD_W-1]}}, dprod_reg};
        end

        if (state_reg == ST_DIST)
        begin
            d_reg <= d_calc;
            if (!have_first_reg)
            begin
                first_reg   <= v_reg;
                first_d_reg <= d_calc;
            end
        end

        if (state_reg == ST_NEXT && !pend_a_reg && !pend_b_reg && !pend_c_reg && !pend_m_reg)
        begin
            prev_reg   <= v_reg;
            prev_d_reg <= d_reg;
        end

        if (state_reg == ST_NEXT && !pend_a_reg)
        begin
            if (pend_b_reg)
            begin
                res_reg     <= v_reg;
                res_vld_reg <= 1'b1;
            end
            else if (!pend_c_reg && pend_m_reg)
            begin
                for (int i = 0; i < NCOMP; i++)
                    res_reg[i] <= '0;
                res_vld_reg <= 1'b0;
            end
        end

        if (state_reg == ST_DIV_WAIT && div_rsp.done)
            frac_reg <= div_rsp.quo;

        if (state_reg == ST_LERP)
        begin
            res_vld_reg <= 1'b1;
            if (j_reg < 3'(NCOMP))
                lprod_reg <= mul_p[LPROD_W-1:0];
            if (j_reg != '0)
                res_reg[jm1] <= a_sel[jm1] + lprod_shift[COORD_W-1:0];
        end
    end

    // output register, loaded when the sequencer hands over a result
    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_ch.out_x     <= res_reg[0];
            out_ch.out_y     <= res_reg[1];
            out_ch.out_z     <= res_reg[2];
            out_ch.out_s     <= res_reg[3];
            out_ch.out_t     <= res_reg[4];
            out_ch.out_valid <= res_vld_reg;
            out_ch.out_last  <= last_reg && !pend_a_reg && !pend_b_reg &&
                                !pend_c_reg && !pend_m_reg;
        end
    end

    assign out_ch.valid = ovalid_reg;

endmodule

>>> hdl/ppc_checker.sv
module ppc_checker (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_vld,
    input logic                    out_rdy,
    input logic [ppc_pkg::COORD_W-1:0] out_x,
    input logic                    out_valid,
    input logic                    out_last
);
    import ppc_pkg::*;

    // a held result does not change
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld && !out_rdy |=> out_vld && $stable(out_x) && $stable(out_last))
        else $error("result changed while stalled");

    // an accepted item keeps the sequencer busy through the distance step
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> (!in_ready) [*6])
        else $error("ready too soon after accept");

    // an empty marker always ends the polygon and carries zeros
    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld && !out_valid |-> out_last && out_x == '0)
        else $error("bad end marker");

endmodule

bind polygon_plane_clipper_unit ppc_checker u_ppc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_vld   (out_ch.valid),
    .out_rdy   (out_ch.ready),
    .out_x     (out_ch.out_x),
    .out_valid (out_ch.out_valid),
    .out_last  (out_ch.out_last)
);
